/* hw/rtl/tsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

    // Register indexes of the configuration channel.
    typedef enum logic [2:0] {
        CFG_FREQUENCY = 3'd0,
        CFG_PERIOD    = 3'd1,
        CFG_DELAY     = 3'd2,
        CFG_STEP      = 3'd3,
        CFG_HORIZON   = 3'd4
    } t_cfg_index;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef struct packed {
        logic [25:0] point_rate;
        logic [16:0] planner_period;
        logic [16:0] control_delay;
        logic [16:0] control_step;
        logic [5:0]  horizon_steps;
    } t_cfg;

    // One classified input transaction as it travels through the queue.
    typedef struct packed {
        logic               is_query;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] jerk_x;
        logic signed [31:0] jerk_y;
        logic signed [18:0] heading;
        logic signed [31:0] heading_rate;
        logic               end_of_path;
    } t_item;

    localparam logic [25:0] FREQUENCY_RST = 26'd655360;
    localparam logic [16:0] PERIOD_RST    = 17'd6554;
    localparam logic [16:0] DELAY_RST     = 17'd0;
    localparam logic [16:0] STEP_RST      = 17'd6554;
    localparam logic [5:0]  HORIZON_RST   = 6'd20;

    // Half turn and full turn in Q16.16 radians.
    localparam logic signed [20:0] PI_Q     = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q = 21'sd411774;

    // floor(v / 6) == (v * RECIP6) >> RECIP6_SHIFT for every v below 2^19.
    localparam logic [17:0] RECIP6       = 18'd174763;
    localparam int          RECIP6_SHIFT = 20;

endpackage

`default_nettype wire

/* hw/rtl/tsr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tsr_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] jerk_x;
    logic signed [31:0] jerk_y;
    logic signed [18:0] heading;
    logic signed [31:0] heading_rate;
    logic               end_of_path;

    modport source (
        output valid, command, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
               jerk_x, jerk_y, heading, heading_rate, end_of_path,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
               jerk_x, jerk_y, heading, heading_rate, end_of_path,
        output ready
    );
endinterface

interface tsr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_vx;
    logic signed [31:0] ref_vy;
    logic signed [31:0] ref_heading;
    logic signed [31:0] ref_heading_rate;
    logic [4:0]         step_number;
    logic               last_of_run;
    logic [1:0]         status;

    modport source (
        output valid, ref_x, ref_y, ref_vx, ref_vy, ref_heading,
               ref_heading_rate, step_number, last_of_run, status,
        input  ready
    );
    modport sink (
        input  valid, ref_x, ref_y, ref_vx, ref_vy, ref_heading,
               ref_heading_rate, step_number, last_of_run, status,
        output ready
    );
endinterface

interface tsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [25:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/trajectory_reference_sampler.sv */
// Trajectory reference sampler. Input transactions arrive on i_item: a load
// (command 0) appends one planner point to the store, a load with end_of_path
// closes the trajectory, and the next load after that starts a new one.
// A query (command 1) brings the current x,y position; the block returns one
// result per horizon step on o_result, the final one marked by last_of_run.
// A query on an empty store returns a single result with status 1.
// Registers are written on i_cfg at any cycle that valid is high; write them
// only while no transaction is in flight.
// Loads stream at one per cycle while the back end is idle and produce
// no result. A query holds the input side while the back end walks the
// store at one point per cycle, then runs its step sequence (S_OFFS
// through S_OUT) once per horizon step. A stalled receiver holds the
// current result in the output register and the step sequence waits on
// it; a two-entry queue keeps input capture going during that time.
// Reset empties the store and restores register defaults at once; there is
// no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_reference_sampler #(
    parameter int TRAJ_DEPTH  = 256,
    parameter int HORIZON_MAX = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsr_in_if.sink     i_item,
    tsr_out_if.source  o_result,
    tsr_cfg_if.sink    i_cfg
);

    tsr_pkg::t_cfg  r_cfg;
    logic           front_valid;
    logic           front_ready;
    tsr_pkg::t_item front_item;
    logic           q_valid;
    logic           q_pop;
    tsr_pkg::t_item q_item;

    // Registers are always writable; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_rate     <= tsr_pkg::FREQUENCY_RST;
            r_cfg.planner_period <= tsr_pkg::PERIOD_RST;
            r_cfg.control_delay  <= tsr_pkg::DELAY_RST;
            r_cfg.control_step   <= tsr_pkg::STEP_RST;
            r_cfg.horizon_steps  <= tsr_pkg::HORIZON_RST;
        end else if (i_cfg.valid) begin
            case (tsr_pkg::t_cfg_index'(i_cfg.index))
                tsr_pkg::CFG_FREQUENCY: r_cfg.point_rate     <= i_cfg.data;
                tsr_pkg::CFG_PERIOD:    r_cfg.planner_period <= i_cfg.data[16:0];
                tsr_pkg::CFG_DELAY:     r_cfg.control_delay  <= i_cfg.data[16:0];
                tsr_pkg::CFG_STEP:      r_cfg.control_step   <= i_cfg.data[16:0];
                tsr_pkg::CFG_HORIZON:   r_cfg.horizon_steps  <= i_cfg.data[5:0];
                default: ;
            endcase
        end
    end

    // Front end: captures and classifies each input transaction.
    tsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    // Short queue that lets the front end keep accepting while a query runs.
    tsr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_item   (q_item)
    );

    // Back end: owns the store, the nearest search and the step sequence.
    tsr_back #(
        .TRAJ_DEPTH  (TRAJ_DEPTH),
        .HORIZON_MAX (HORIZON_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

/* hw/rtl/tsr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tsr_in_if.sink             i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output tsr_pkg::t_item     o_item
);

    logic           r_valid;
    tsr_pkg::t_item r_item;

    assign i_item.ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Classify the transaction as it is captured.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.is_query     <= (tsr_pkg::t_command'(i_item.command) == tsr_pkg::CMD_QUERY);
            r_item.pos_x        <= i_item.pos_x;
            r_item.pos_y        <= i_item.pos_y;
            r_item.vel_x        <= i_item.vel_x;
            r_item.vel_y        <= i_item.vel_y;
            r_item.acc_x        <= i_item.acc_x;
            r_item.acc_y        <= i_item.acc_y;
            r_item.jerk_x       <= i_item.jerk_x;
            r_item.jerk_y       <= i_item.jerk_y;
            r_item.heading      <= i_item.heading;
            r_item.heading_rate <= i_item.heading_rate;
            r_item.end_of_path  <= i_item.end_of_path;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tsr_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsr_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire tsr_pkg::t_item  i_push_item,
    output logic                 o_pop_valid,
    input  wire logic            i_pop,
    output tsr_pkg::t_item       o_pop_item
);

    tsr_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           c_push;
    logic           c_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_item   = r_mem[r_rp];
    assign c_push       = i_push_valid && o_push_ready;
    assign c_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_wp <= !r_wp;
            end
            if (c_pop) begin
                r_rp <= !r_rp;
            end
            if (c_push && !c_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (c_pop && !c_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tsr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsr_back #(
    parameter int TRAJ_DEPTH  = 256,
    parameter int HORIZON_MAX = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tsr_pkg::t_cfg   i_cfg,
    input  wire logic            i_q_valid,
    output logic                 o_q_pop,
    input  wire tsr_pkg::t_item  i_q_item,
    tsr_out_if.source            o_result
);

    localparam int AW   = $clog2(TRAJ_DEPTH);
    localparam int CW   = AW + 1;
    localparam int SW   = $clog2(HORIZON_MAX + 1);
    localparam int QW   = (AW + 16 > 34) ? AW + 17 : 35;
    localparam int SUMW = 54;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_OFFS, S_MUL, S_INDEX, S_FETCH, S_CUR, S_NEXT,
        S_TERM, S_JERK, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Trajectory store.
    logic [63:0] mem_pos  [TRAJ_DEPTH];
    logic [63:0] mem_vel  [TRAJ_DEPTH];
    logic [63:0] mem_acc  [TRAJ_DEPTH];
    logic [63:0] mem_jerk [TRAJ_DEPTH];
    logic [50:0] mem_head [TRAJ_DEPTH];
    logic [63:0] r_pos_q;
    logic [63:0] r_vel_q;
    logic [63:0] r_acc_q;
    logic [63:0] r_jerk_q;
    logic [50:0] r_head_q;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic             r_closed;
    logic             r_ovf;
    logic [CW-1:0]    r_scan_i;
    logic             r_v1, r_v2, r_v3;
    logic [SW-1:0]    r_s;
    logic [SW-1:0]    r_steps;
    tsr_pkg::t_status r_status;

    logic               r_out_valid;
    logic signed [31:0] r_o_x, r_o_y, r_o_vx, r_o_vy, r_o_head, r_o_rate;
    logic [4:0]         r_o_step;
    logic               r_o_last;
    tsr_pkg::t_status   r_o_status;

    // Datapath registers.
    logic signed [31:0] r_cx, r_cy;
    logic [AW-1:0]      r_i1, r_i2, r_i3;
    logic signed [32:0] r_dx, r_dy;
    logic signed [65:0] r_sqx, r_sqy;
    logic [65:0]        r_best;
    logic [AW-1:0]      r_nearest;
    logic [23:0]        r_offs;
    logic [49:0]        r_prod;
    logic [QW-1:0]      r_q;
    logic [16:0]        r_dtu;
    logic [33:0]        r_sq;
    logic [50:0]        r_cube;
    logic [16:0]        r_c2;
    logic [16:0]        r_c3;
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay, r_jx, r_jy, r_r0;
    logic signed [18:0] r_h0;
    logic signed [20:0] r_dh;
    logic signed [32:0] r_dr;
    logic signed [49:0] r_tv1x, r_tv1y, r_ta1x, r_ta1y, r_ta2x, r_ta2y;
    logic signed [49:0] r_tj2x, r_tj2y, r_tj3x, r_tj3y;
    logic signed [37:0] r_th;
    logic signed [49:0] r_tr;

    logic               c_out_free;
    logic               c_wr;
    logic [CW-1:0]      c_eff;
    logic [AW-1:0]      c_rd_addr;
    logic               c_issue;
    logic [65:0]        c_dist;
    logic [QW-1:0]      c_qsum;
    logic [QW-1:0]      c_lastq;
    logic [CW-1:0]      c_cnt_m1;
    logic [AW-1:0]      c_idx;
    logic [AW-1:0]      c_nxt;
    logic signed [20:0] c_dhraw;
    logic signed [20:0] c_dh;
    logic signed [17:0] c_c1s, c_c2s, c_c3s;
    logic signed [16:0] c_alpha;
    logic signed [SUMW-1:0] c_sum_x, c_sum_y, c_sum_vx, c_sum_vy;
    logic               c_last;
    logic [SW-1:0]      c_steps;

    assign c_out_free = !r_out_valid || o_result.ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid && (!i_q_item.is_query || c_out_free);
    assign c_eff      = r_closed ? '0 : r_count;
    assign c_wr       = o_q_pop && !i_q_item.is_query && (c_eff < CW'(TRAJ_DEPTH));
    assign c_issue    = (r_state == S_SCAN) && (r_scan_i < r_count);
    assign c_cnt_m1   = r_count - CW'(1);
    assign c_idx      = r_q[AW+15:16];
    assign c_nxt      = (CW'(c_idx) == c_cnt_m1) ? c_idx : c_idx + AW'(1);
    assign c_dist     = 66'(r_sqx) + 66'(r_sqy);
    assign c_qsum     = QW'({r_nearest, 16'h0000}) + QW'(r_prod[49:16]);
    assign c_lastq    = QW'({c_cnt_m1, 16'h0000});
    assign c_last     = (r_s == r_steps - SW'(1));

    always_comb begin
        if (i_cfg.horizon_steps == 6'd0) begin
            c_steps = SW'(1);
        end else if (7'(i_cfg.horizon_steps) > 7'(HORIZON_MAX)) begin
            c_steps = SW'(HORIZON_MAX);
        end else begin
            c_steps = SW'(i_cfg.horizon_steps);
        end
    end

    always_comb begin
        case (r_state)
            S_SCAN:  c_rd_addr = r_scan_i[AW-1:0];
            S_FETCH: c_rd_addr = c_idx;
            S_CUR:   c_rd_addr = c_nxt;
            default: c_rd_addr = '0;
        endcase
    end

    // Yaw difference wrapped into (-pi, pi]; one correction covers every input.
    always_comb begin
        c_dhraw = 21'($signed(r_head_q[18:0])) - 21'(r_h0);
        if (c_dhraw > tsr_pkg::PI_Q) begin
            c_dh = c_dhraw - tsr_pkg::TWO_PI_Q;
        end else if (c_dhraw <= -tsr_pkg::PI_Q) begin
            c_dh = c_dhraw + tsr_pkg::TWO_PI_Q;
        end else begin
            c_dh = c_dhraw;
        end
    end

    assign c_c1s   = $signed({1'b0, r_dtu});
    assign c_c2s   = $signed({1'b0, r_c2});
    assign c_c3s   = $signed({1'b0, r_c3});
    assign c_alpha = $signed({1'b0, r_q[15:0]});

    assign c_sum_x  = (SUMW'(r_px) <<< 16) + SUMW'(r_tv1x) + SUMW'(r_ta2x) + SUMW'(r_tj3x);
    assign c_sum_y  = (SUMW'(r_py) <<< 16) + SUMW'(r_tv1y) + SUMW'(r_ta2y) + SUMW'(r_tj3y);
    assign c_sum_vx = (SUMW'(r_vx) <<< 16) + SUMW'(r_ta1x) + SUMW'(r_tj2x);
    assign c_sum_vy = (SUMW'(r_vy) <<< 16) + SUMW'(r_ta1y) + SUMW'(r_tj2y);

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            mem_pos[c_eff[AW-1:0]]  <= {i_q_item.pos_y, i_q_item.pos_x};
            mem_vel[c_eff[AW-1:0]]  <= {i_q_item.vel_y, i_q_item.vel_x};
            mem_acc[c_eff[AW-1:0]]  <= {i_q_item.acc_y, i_q_item.acc_x};
            mem_jerk[c_eff[AW-1:0]] <= {i_q_item.jerk_y, i_q_item.jerk_x};
            mem_head[c_eff[AW-1:0]] <= {i_q_item.heading_rate, i_q_item.heading};
        end
        r_pos_q  <= mem_pos[c_rd_addr];
        r_vel_q  <= mem_vel[c_rd_addr];
        r_acc_q  <= mem_acc[c_rd_addr];
        r_jerk_q <= mem_jerk[c_rd_addr];
        r_head_q <= mem_head[c_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_closed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_scan_i    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_s         <= '0;
            r_steps     <= '0;
            r_status    <= tsr_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= c_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && !i_q_item.is_query) begin
                        r_closed <= i_q_item.end_of_path;
                        if (c_eff < CW'(TRAJ_DEPTH)) begin
                            r_count <= c_eff + CW'(1);
                            r_ovf   <= r_ovf && !r_closed;
                        end else begin
                            r_count <= c_eff;
                            r_ovf   <= 1'b1;
                        end
                    end else if (o_q_pop) begin
                        if (r_count == '0) begin
                            r_out_valid <= 1'b1;
                            r_o_x       <= '0;
                            r_o_y       <= '0;
                            r_o_vx      <= '0;
                            r_o_vy      <= '0;
                            r_o_head    <= '0;
                            r_o_rate    <= '0;
                            r_o_step    <= '0;
                            r_o_last    <= 1'b1;
                            r_o_status  <= tsr_pkg::ST_EMPTY;
                        end else begin
                            r_scan_i <= '0;
                            r_steps  <= c_steps;
                            r_status <= r_ovf ? tsr_pkg::ST_DROPPED : tsr_pkg::ST_OK;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (c_issue) begin
                        r_scan_i <= r_scan_i + CW'(1);
                    end else if (!r_v1 && !r_v2 && !r_v3) begin
                        r_s     <= '0;
                        r_state <= S_OFFS;
                    end
                end
                S_OFFS:  r_state <= S_MUL;
                S_MUL:   r_state <= S_INDEX;
                S_INDEX: r_state <= S_FETCH;
                S_FETCH: r_state <= S_CUR;
                S_CUR:   r_state <= S_NEXT;
                S_NEXT:  r_state <= S_TERM;
                S_TERM:  r_state <= S_JERK;
                S_JERK:  r_state <= S_OUT;
                S_OUT: begin
                    if (c_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_x       <= sat32(40'(c_sum_x >>> 16));
                        r_o_y       <= sat32(40'(c_sum_y >>> 16));
                        r_o_vx      <= sat32(40'(c_sum_vx >>> 16));
                        r_o_vy      <= sat32(40'(c_sum_vy >>> 16));
                        r_o_head    <= 32'(r_h0) + 32'(r_th >>> 16);
                        r_o_rate    <= sat32(40'(r_r0) + 40'(r_tr >>> 16));
                        r_o_step    <= 5'(r_s);
                        r_o_last    <= c_last;
                        r_o_status  <= r_status;
                        if (c_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_s     <= r_s + SW'(1);
                            r_state <= S_OFFS;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Nearest-point search: read, difference, square, then accumulate.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cx <= i_q_item.pos_x;
            r_cy <= i_q_item.pos_y;
        end
        r_i1  <= r_scan_i[AW-1:0];
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_dx  <= 33'($signed(r_pos_q[31:0])) - 33'(r_cx);
        r_dy  <= 33'($signed(r_pos_q[63:32])) - 33'(r_cy);
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        if (r_v3 && (r_i3 == '0 || c_dist < r_best)) begin
            r_best    <= c_dist;
            r_nearest <= r_i3;
        end
    end

    // Per-step arithmetic, one stage for each state from S_OFFS to S_JERK.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_OFFS: r_offs <= 24'(i_cfg.control_delay) + 24'(r_s) * 24'(i_cfg.control_step);
            S_MUL:  r_prod <= 50'(r_offs) * 50'(i_cfg.point_rate);
            S_INDEX: r_q <= (c_qsum > c_lastq) ? c_lastq : c_qsum;
            S_FETCH: r_dtu <= 17'((33'(r_q[15:0]) * 33'(i_cfg.planner_period)) >> 16);
            S_CUR: begin
                r_px <= $signed(r_pos_q[31:0]);
                r_py <= $signed(r_pos_q[63:32]);
                r_vx <= $signed(r_vel_q[31:0]);
                r_vy <= $signed(r_vel_q[63:32]);
                r_ax <= $signed(r_acc_q[31:0]);
                r_ay <= $signed(r_acc_q[63:32]);
                r_jx <= $signed(r_jerk_q[31:0]);
                r_jy <= $signed(r_jerk_q[63:32]);
                r_h0 <= $signed(r_head_q[18:0]);
                r_r0 <= $signed(r_head_q[50:19]);
                r_sq <= 34'(r_dtu) * 34'(r_dtu);
            end
            S_NEXT: begin
                r_dh   <= c_dh;
                r_dr   <= 33'($signed(r_head_q[50:19])) - 33'(r_r0);
                r_cube <= 51'(r_sq) * 51'(r_dtu);
                r_c2   <= r_sq[33:17];
            end
            S_TERM: begin
                r_c3   <= 17'((37'(r_cube[50:32]) * 37'(tsr_pkg::RECIP6))
                              >> tsr_pkg::RECIP6_SHIFT);
                r_tv1x <= r_vx * c_c1s;
                r_tv1y <= r_vy * c_c1s;
                r_ta1x <= r_ax * c_c1s;
                r_ta1y <= r_ay * c_c1s;
                r_ta2x <= r_ax * c_c2s;
                r_ta2y <= r_ay * c_c2s;
                r_tj2x <= r_jx * c_c2s;
                r_tj2y <= r_jy * c_c2s;
                r_th   <= c_alpha * r_dh;
                r_tr   <= c_alpha * r_dr;
            end
            S_JERK: begin
                r_tj3x <= r_jx * c_c3s;
                r_tj3y <= r_jy * c_c3s;
            end
            default: ;
        endcase
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.ref_x            = r_o_x;
    assign o_result.ref_y            = r_o_y;
    assign o_result.ref_vx           = r_o_vx;
    assign o_result.ref_vy           = r_o_vy;
    assign o_result.ref_heading      = r_o_head;
    assign o_result.ref_heading_rate = r_o_rate;
    assign o_result.step_number      = r_o_step;
    assign o_result.last_of_run      = r_o_last;
    assign o_result.status           = r_o_status;

endmodule

`default_nettype wire
